// ----- design/mbe_pkg.sv -----
// Package for the escape-time pixel evaluator.
// Holds register indexes, reset values and the Q6.26 saturation helpers.
// No dependencies.
package mbe_pkg;

   localparam int FRAC_BITS        = 26;
   localparam int FRAME_WIDTH_DEF  = 1024;
   localparam int FRAME_HEIGHT_DEF = 1024;

   localparam logic [2:0] CSR_ORIGIN_RE  = 3'd0;
   localparam logic [2:0] CSR_ORIGIN_IM  = 3'd1;
   localparam logic [2:0] CSR_STEP_SIZE  = 3'd2;
   localparam logic [2:0] CSR_ITER_LIMIT = 3'd3;
   localparam logic [2:0] CSR_ESCAPE_SQR = 3'd4;

   localparam logic [30:0] STEP_SIZE_RST  = 31'd131072;
   localparam logic [15:0] ITER_LIMIT_RST = 16'd256;
   localparam logic [30:0] ESCAPE_SQR_RST = 31'd268435456;

   localparam logic [7:0] COLOUR_LOW = 8'd255;

   typedef struct packed {
      logic signed [31:0] a;
      logic signed [31:0] b;
   } mul_operands_type;

   function automatic logic signed [31:0] sat_s32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> FRAC_BITS;
      return sat_s32({{2{s[63]}}, s});
   endfunction

   function automatic logic signed [65:0] ext66(input logic signed [31:0] v);
      return {{34{v[31]}}, v};
   endfunction

endpackage

// ----- design/mbe_mul.sv -----
// Shared signed 32x32 multiplier with registered 64-bit product.
// Depends on mbe_pkg for the operand struct.
module mbe_mul (
   input  logic                     clock,
   input  mbe_pkg::mul_operands_type ops,
   output logic signed [63:0]       prod
);
   import mbe_pkg::*;

   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   assign prod_in = 64'(ops.a) * 64'(ops.b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

// ----- design/mandelbrot_escape_time.sv -----
// Top level of the escape-time pixel evaluator: registers, sequencer, result.
// Depends on mbe_pkg and mbe_mul.
// One pixel at a time: start is taken while busy is low, and the result appears
// for one cycle with rsp_valid, which cannot be held off. The escape count is the
// iteration cap when the pixel is inside. Every iteration runs its three products
// x*x, y*y, x*y through one shared registered multiplier, followed by the escape
// test and update step.
module mandelbrot_escape_time #(
   parameter int FRAME_WIDTH  = mbe_pkg::FRAME_WIDTH_DEF,
   parameter int FRAME_HEIGHT = mbe_pkg::FRAME_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [9:0]  req_column,
   input  logic [9:0]  req_row,
   output logic        rsp_valid,
   output logic [31:0] rsp_colour,
   output logic [15:0] rsp_escape_count,
   output logic        rsp_inside_res,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import mbe_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL_RE, ST_MUL_IM, ST_LOAD_IM,
      ST_MUL_YY, ST_MUL_XY, ST_CHECK, ST_UPD_Y
   } state_type;

   logic signed [31:0] origin_re_ff, origin_im_ff;
   logic [30:0]        step_size_ff, escape_sqr_ff;
   logic [15:0]        iter_limit_ff;

   state_type          state_ff, state_in;
   logic [9:0]         col_ff, col_in, row_ff, row_in;
   logic signed [31:0] c_re_ff, c_re_in, c_im_ff, c_im_in;
   logic signed [31:0] x_ff, x_in, y_ff, y_in;
   logic signed [31:0] sx_ff, sx_in, sy_ff, sy_in, pxy_ff, pxy_in;
   logic [15:0]        k_ff, k_in;
   logic               valid_ff, valid_in;
   logic [31:0]        colour_ff, colour_in;
   logic [15:0]        count_ff, count_in;
   logic               inside_ff, inside_in;

   mul_operands_type   ops;
   logic signed [63:0] prod;
   logic signed [32:0] mag;
   logic               accept;

   mbe_mul u_mul (
      .clock (clock),
      .ops   (ops),
      .prod  (prod)
   );

   assign accept = start && (state_ff == ST_IDLE);
   assign mag    = 33'(sx_ff) + 33'(sy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_re_ff  <= '0;
         origin_im_ff  <= '0;
         step_size_ff  <= STEP_SIZE_RST;
         iter_limit_ff <= ITER_LIMIT_RST;
         escape_sqr_ff <= ESCAPE_SQR_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_ORIGIN_RE:  origin_re_ff  <= csr_wdata;
            CSR_ORIGIN_IM:  origin_im_ff  <= csr_wdata;
            CSR_STEP_SIZE:  step_size_ff  <= csr_wdata[30:0];
            CSR_ITER_LIMIT: iter_limit_ff <= csr_wdata[15:0];
            CSR_ESCAPE_SQR: escape_sqr_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      ops       = '0;
      state_in  = state_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      c_re_in   = c_re_ff;
      c_im_in   = c_im_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      sx_in     = sx_ff;
      sy_in     = sy_ff;
      pxy_in    = pxy_ff;
      k_in      = k_ff;
      valid_in  = 1'b0;
      colour_in = colour_ff;
      count_in  = count_ff;
      inside_in = inside_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               col_in   = (int'(req_column) > FRAME_WIDTH - 1) ?
                          10'(FRAME_WIDTH - 1) : req_column;
               row_in   = (int'(req_row) > FRAME_HEIGHT - 1) ?
                          10'(FRAME_HEIGHT - 1) : req_row;
               k_in     = '0;
               state_in = ST_MUL_RE;
            end
         end
         ST_MUL_RE: begin
            ops.a    = {22'd0, col_ff};
            ops.b    = {1'b0, step_size_ff};
            state_in = ST_MUL_IM;
         end
         ST_MUL_IM: begin
            ops.a    = {22'd0, row_ff};
            ops.b    = {1'b0, step_size_ff};
            c_re_in  = sat_s32(ext66(origin_re_ff) + {{2{prod[63]}}, prod});
            x_in     = c_re_in;
            state_in = ST_LOAD_IM;
         end
         ST_LOAD_IM: begin
            ops.a    = x_ff;
            ops.b    = x_ff;
            c_im_in  = sat_s32(ext66(origin_im_ff) + {{2{prod[63]}}, prod});
            y_in     = c_im_in;
            state_in = ST_MUL_YY;
         end
         ST_MUL_YY: begin
            ops.a    = y_ff;
            ops.b    = y_ff;
            sx_in    = qsat(prod);
            state_in = ST_MUL_XY;
         end
         ST_MUL_XY: begin
            ops.a    = x_ff;
            ops.b    = y_ff;
            sy_in    = qsat(prod);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            pxy_in = qsat(prod);
            if (k_ff >= iter_limit_ff) begin
               valid_in  = 1'b1;
               inside_in = 1'b1;
               count_in  = iter_limit_ff;
               colour_in = {16'd0, iter_limit_ff};
               state_in  = ST_IDLE;
            end else if (mag > $signed({2'b00, escape_sqr_ff})) begin
               valid_in  = 1'b1;
               inside_in = 1'b0;
               count_in  = k_ff;
               colour_in = {k_ff, 16'd0} | {7'd0, k_ff, 9'd0} | {24'd0, COLOUR_LOW};
               state_in  = ST_IDLE;
            end else begin
               k_in     = k_ff + 16'd1;
               x_in     = sat_s32(ext66(sx_ff) - ext66(sy_ff) + ext66(c_re_ff));
               state_in = ST_UPD_Y;
            end
         end
         ST_UPD_Y: begin
            ops.a    = x_ff;
            ops.b    = x_ff;
            y_in     = sat_s32((ext66(pxy_ff) <<< 1) + ext66(c_im_ff));
            state_in = ST_MUL_YY;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      col_ff    <= col_in;
      row_ff    <= row_in;
      c_re_ff   <= c_re_in;
      c_im_ff   <= c_im_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      sx_ff     <= sx_in;
      sy_ff     <= sy_in;
      pxy_ff    <= pxy_in;
      k_ff      <= k_in;
      colour_ff <= colour_in;
      count_ff  <= count_in;
      inside_ff <= inside_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_colour       = colour_ff;
   assign rsp_escape_count = count_ff;
   assign rsp_inside_res   = inside_ff;

`ifndef NO_ASSERTIONS
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("item accepted but block not busy");
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy))) else $error("result outside item end");
   a_inside_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_inside_res) |-> (rsp_escape_count == iter_limit_ff))
      else $error("inside count differs from cap");
   a_escape_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_res) |-> (rsp_escape_count < iter_limit_ff))
      else $error("escape count reaches cap");
`endif

endmodule
